/* sv/torq_pkg.sv */
// ----------------------------------------------------------------------------
// torq_pkg
// Shared types and constants of the timestamp ordered request queue.
// ----------------------------------------------------------------------------
package torq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W    = 4;
  localparam int TIME_W  = 15;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;
  localparam int ENTRY_W = TIME_W + ID_W;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_EV,
    S_REM_RD,
    S_REM_EV,
    S_HEAD_RD,
    S_HEAD_EV
  } state_e;

endpackage

/* sv/torq_ram.sv */
// ----------------------------------------------------------------------------
// torq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module torq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/timestamp_ordered_request_queue.sv */
// ----------------------------------------------------------------------------
// timestamp_ordered_request_queue
// Sorted (time, id) request queue held in one RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
// Sequence: an insert walks from the tail, moving each entry not below the new key
// back by one slot, then reads the head; a remove scans every entry; a full insert
// goes straight to the head read. The result lands in an output register. Each
// visited entry costs a RAM read state and an evaluate state.
// Throughput: one item at a time; the next item is taken once the result is
// registered. Reset empties the queue and clears own_id; RAM contents are not
// cleared (entries at or above the count are never used).

module timestamp_ordered_request_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [torq_pkg::ID_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [torq_pkg::ID_W-1:0]   requester_id_i,
  input  logic [torq_pkg::TIME_W-1:0] request_time_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [torq_pkg::POS_W-1:0]  position_o,
  output logic [torq_pkg::COUNT_W-1:0] count_o,
  output logic                        head_is_own_o,
  output logic [torq_pkg::ID_W-1:0]   head_id_o,
  output logic [torq_pkg::TIME_W-1:0] head_time_o
);

  import torq_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    k_q, k_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    k_m1;
  logic                found_q, found_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  status_e             stat_q, stat_d;
  logic [ID_W-1:0]     new_id_q, new_id_d;
  logic [TIME_W-1:0]   new_time_q, new_time_d;
  logic [ID_W-1:0]     own_id_q;

  logic                out_valid_q;
  logic                out_load;
  status_e             o_stat_q;
  logic [POS_W-1:0]    o_pos_q;
  logic [COUNT_W-1:0]  o_cnt_q;
  logic                o_own_q;
  logic [ID_W-1:0]     o_hid_q;
  logic [TIME_W-1:0]   o_htime_q;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [ENTRY_W-1:0]  new_key;
  logic [ID_W-1:0]     rd_id;

  torq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign new_key = {new_time_q, new_id_q};
  assign rd_id   = ram_rdata[ID_W-1:0];
  assign k_m1    = k_q - 1'b1;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    found_d    = found_q;
    pos_d      = pos_q;
    stat_d     = stat_q;
    new_id_d   = new_id_q;
    new_time_d = new_time_q;
    ram_we     = 1'b0;
    ram_waddr  = k_q[IDX_W-1:0];
    ram_wdata  = new_key;
    ram_raddr  = k_q[IDX_W-1:0];
    out_load   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          new_id_d   = requester_id_i;
          new_time_d = request_time_i;
          pos_d      = '0;
          stat_d     = ST_DONE;
          found_d    = 1'b0;
          if (mode_i == MODE_INSERT) begin
            if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
              stat_d  = ST_FULL;
              state_d = S_HEAD_RD;
            end else begin
              k_d     = cnt_q;
              state_d = S_INS_RD;
            end
          end else begin
            k_d     = '0;
            state_d = S_REM_RD;
          end
        end
      end
      S_INS_RD: begin
        ram_raddr = k_m1[IDX_W-1:0];
        if (k_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = new_key;
          pos_d     = '0;
          cnt_d     = cnt_q + 1'b1;
          state_d   = S_HEAD_RD;
        end else begin
          state_d = S_INS_EV;
        end
      end
      S_INS_EV: begin
        ram_we    = 1'b1;
        ram_waddr = k_q[IDX_W-1:0];
        if (ram_rdata >= new_key) begin
          ram_wdata = ram_rdata;
          k_d       = k_m1;
          state_d   = S_INS_RD;
        end else begin
          ram_wdata = new_key;
          pos_d     = k_q[IDX_W-1:0];
          cnt_d     = cnt_q + 1'b1;
          state_d   = S_HEAD_RD;
        end
      end
      S_REM_RD: begin
        ram_raddr = k_q[IDX_W-1:0];
        if (k_q == cnt_q) begin
          if (found_q) begin
            cnt_d = cnt_q - 1'b1;
          end else begin
            stat_d = ST_MISS;
          end
          state_d = S_HEAD_RD;
        end else begin
          state_d = S_REM_EV;
        end
      end
      S_REM_EV: begin
        if (found_q) begin
          ram_we    = 1'b1;
          ram_waddr = k_m1[IDX_W-1:0];
          ram_wdata = ram_rdata;
        end else if (rd_id == new_id_q) begin
          found_d = 1'b1;
          pos_d   = k_q[IDX_W-1:0];
        end
        k_d     = k_q + 1'b1;
        state_d = S_REM_RD;
      end
      S_HEAD_RD: begin
        ram_raddr = '0;
        state_d   = S_HEAD_EV;
      end
      S_HEAD_EV: begin
        // keep the head on the read port while the output is stalled
        ram_raddr = '0;
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      own_id_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        own_id_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    found_q    <= found_d;
    pos_q      <= pos_d;
    stat_q     <= stat_d;
    new_id_q   <= new_id_d;
    new_time_q <= new_time_d;
    if (out_load) begin
      o_stat_q <= stat_q;
      o_pos_q  <= POS_W'(pos_q);
      o_cnt_q  <= COUNT_W'(cnt_q);
      if (cnt_q != '0) begin
        o_hid_q   <= rd_id;
        o_htime_q <= ram_rdata[ENTRY_W-1:ID_W];
        o_own_q   <= (rd_id == own_id_q);
      end else begin
        o_hid_q   <= '0;
        o_htime_q <= '0;
        o_own_q   <= 1'b0;
      end
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = o_stat_q;
  assign position_o    = o_pos_q;
  assign count_o       = o_cnt_q;
  assign head_is_own_o = o_own_q;
  assign head_id_o     = o_hid_q;
  assign head_time_o   = o_htime_q;

endmodule

/* verif/tb_timestamp_ordered_request_queue.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamp_ordered_request_queue
// Drives insert and remove requests into the sorted request queue under
// random source gaps and sink stalls. A sorted-list predictor updated at each
// accepted item supplies the expected result, and results are checked in order.
// ----------------------------------------------------------------------------
module tb_timestamp_ordered_request_queue;
  import torq_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;

  typedef logic [ENTRY_W-1:0] entry_t;  // {time, id}: compares as the sort key

  typedef struct packed {
    logic              mode;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] t;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [POS_W-1:0]   pos;
    logic [COUNT_W-1:0] cnt;
    logic               own;
    logic [ID_W-1:0]    hid;
    logic [TIME_W-1:0]  htime;
  } resp_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [ID_W-1:0]     cfg_wdata_i    = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                mode_i         = MODE_INSERT;
  logic [ID_W-1:0]     requester_id_i = '0;
  logic [TIME_W-1:0]   request_time_i = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [1:0]          status_o;
  logic [POS_W-1:0]    position_o;
  logic [COUNT_W-1:0]  count_o;
  logic                head_is_own_o;
  logic [ID_W-1:0]     head_id_o;
  logic [TIME_W-1:0]   head_time_o;

  req_t            pending_reqs[$];
  resp_t           expected_results[$];
  entry_t          plan_q[$];   // queue contents as the stimulus will leave them
  entry_t          book_q[$];   // queue contents after the last accepted item
  req_t            cur_req = '0;
  logic [ID_W-1:0] own_id_copy = '0;
  bit              no_idle = 1'b0;
  int              gap_left = 0;
  int              stall_left = 0;
  int              n_queued = 0;
  int              n_accepted = 0;
  int              n_inserts = 0;
  int              n_removes = 0;
  int              n_results = 0;
  int              n_errors = 0;
  int              n_full = 0;
  int              n_miss = 0;
  int              n_own_head = 0;
  int              max_depth = 0;
  int              idle_cycles = 0;

  timestamp_ordered_request_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .requester_id_i (requester_id_i),
    .request_time_i (request_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .position_o     (position_o),
    .count_o        (count_o),
    .head_is_own_o  (head_is_own_o),
    .head_id_o      (head_id_o),
    .head_time_o    (head_time_o)
  );

  always #10 clk_i = ~clk_i;

  // Applies one request to a sorted queue and returns the result it reports.
  function automatic resp_t serve_request(ref entry_t q[$], input req_t r,
                                          input logic [ID_W-1:0] own);
    resp_t  o;
    int     p;
    entry_t key;
    o = '0;
    o.status = ST_DONE;
    key = {r.t, r.id};
    p = 0;
    if (r.mode == MODE_INSERT) begin
      if (q.size() >= QUEUE_DEPTH) begin
        o.status = ST_FULL;
      end else begin
        while (p < q.size() && q[p] < key) p++;
        q.insert(p, key);
        o.pos = p[POS_W-1:0];
      end
    end else begin
      while (p < q.size() && q[p][ID_W-1:0] != r.id) p++;
      if (p == q.size()) begin
        o.status = ST_MISS;
      end else begin
        q.delete(p);
        o.pos = p[POS_W-1:0];
      end
    end
    o.cnt = COUNT_W'(q.size());
    if (q.size() > 0) begin
      o.hid   = q[0][ID_W-1:0];
      o.htime = q[0][ENTRY_W-1:ID_W];
      o.own   = (q[0][ID_W-1:0] == own);
    end
    return o;
  endfunction

  task automatic add_request(input logic mode, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] t);
    req_t r;
    r = '{mode: mode, id: id, t: t};
    pending_reqs.push_back(r);
    void'(serve_request(plan_q, r, '0));
    n_queued++;
    if (mode == MODE_INSERT) n_inserts++;
    else n_removes++;
  endtask

  task automatic add_random(input int insert_pct);
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] t;
    entry_t            e;
    int                sel;
    id = ID_W'($urandom_range(0, 15));
    t  = TIME_W'($urandom_range(0, 32767));
    if ($urandom_range(0, 99) < insert_pct) begin
      sel = $urandom_range(0, 5);
      if (sel < 2) begin
        t = TIME_W'($urandom_range(0, 7));
      end else if (sel == 3) begin
        t = $urandom_range(0, 1) ? '1 : '0;
      end else if (sel > 3 && plan_q.size() > 0) begin
        e = plan_q[$urandom_range(0, plan_q.size() - 1)];
        t = e[ENTRY_W-1:ID_W];
        if ($urandom_range(0, 1)) id = e[ID_W-1:0];
      end
      add_request(MODE_INSERT, id, t);
    end else begin
      if (plan_q.size() > 0 && $urandom_range(0, 99) < 80)
        id = plan_q[$urandom_range(0, plan_q.size() - 1)][ID_W-1:0];
      add_request(MODE_REMOVE, id, t);
    end
  endtask

  task automatic random_stretch(input int n, input int insert_pct);
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) begin
        while (pending_reqs.size() != 0) @(negedge clk_i);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      add_random(insert_pct);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (n_accepted != n_queued || expected_results.size() != 0);
  endtask

  task automatic set_own_id(input logic [ID_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    own_id_copy <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Source side
  always @(posedge clk_i or negedge rst_ni) begin
    req_t nxt;
    logic took;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      mode_i         <= MODE_INSERT;
      requester_id_i <= '0;
      request_time_i <= '0;
      gap_left       <= 0;
    end else begin
      took = in_valid_i && !in_stall_o;
      if (took) begin
        expected_results.push_back(serve_request(book_q, cur_req, own_id_copy));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid_i || took) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          cur_req        <= nxt;
          mode_i         <= nxt.mode;
          requester_id_i <= nxt.id;
          request_time_i <= nxt.t;
          in_valid_i     <= 1'b1;
          gap_left       <= no_idle ? 0 : $urandom_range(0, 17);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Sink side
  always @(posedge clk_i or negedge rst_ni) begin
    resp_t got;
    resp_t want;
    int    d;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      got = {status_o, position_o, count_o, head_is_own_o, head_id_o, head_time_o};
      n_results++;
      if (got.status == ST_FULL) n_full++;
      if (got.status == ST_MISS) n_miss++;
      if (got.own) n_own_head++;
      if (got.cnt > max_depth) max_depth = got.cnt;
      if (expected_results.size() == 0) begin
        if (n_errors < 10) $display("result %0d arrived with nothing expected", n_results);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          if (n_errors < 10) begin
            $display("result %0d mismatch: expected st %0d pos %0d cnt %0d own %0b head %0d/%0d",
                     n_results, want.status, want.pos, want.cnt, want.own, want.hid,
                     want.htime);
            $display("  got st %0d pos %0d cnt %0d own %0b head %0d/%0d",
                     got.status, got.pos, got.cnt, got.own, got.hid, got.htime);
          end
          n_errors++;
        end
      end
      d = no_idle ? 0 : $urandom_range(0, 17);
      stall_left  <= d;
      out_stall_i <= (d != 0);
    end else if (stall_left > 0 && out_valid_o) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", idle_cycles);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_own_id(4'd15);
    add_request(MODE_REMOVE, 4'd3, 15'd0);
    add_request(MODE_INSERT, 4'd5, 15'd100);
    add_request(MODE_INSERT, 4'd2, 15'd100);
    add_request(MODE_INSERT, 4'd5, 15'd100);
    add_request(MODE_INSERT, 4'd15, 15'd0);
    add_request(MODE_INSERT, 4'd0, 15'd32767);
    add_request(MODE_INSERT, 4'd15, 15'd32767);
    add_request(MODE_INSERT, 4'd0, 15'd0);
    add_request(MODE_INSERT, 4'd7, 15'd50);
    add_request(MODE_INSERT, 4'd10, 15'd16383);
    add_request(MODE_INSERT, 4'd1, 15'd16384);
    add_request(MODE_INSERT, 4'd3, 15'd200);
    add_request(MODE_INSERT, 4'd3, 15'd200);
    add_request(MODE_INSERT, 4'd4, 15'd1);
    add_request(MODE_INSERT, 4'd6, 15'd32766);
    add_request(MODE_INSERT, 4'd8, 15'd7);
    add_request(MODE_INSERT, 4'd12, 15'd100);
    add_request(MODE_INSERT, 4'd9, 15'd5);      // full, dropped
    add_request(MODE_REMOVE, 4'd9, 15'd32767);  // absent id, time ignored
    add_request(MODE_REMOVE, 4'd0, 15'd0);
    add_request(MODE_REMOVE, 4'd5, 15'd0);
    add_request(MODE_REMOVE, 4'd15, 15'd12345);
    add_request(MODE_REMOVE, 4'd15, 15'd0);
    wait_idle();

    set_own_id(4'd0);
    random_stretch(150, 65);
    wait_idle();

    set_own_id(ID_W'($urandom_range(0, 15)));
    random_stretch(150, 35);
    wait_idle();

    set_own_id(4'd15);
    random_stretch(200, 50);
    wait_idle();

    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    $display("%0d requests (%0d inserts, %0d removes), %0d results checked",
             n_queued, n_inserts, n_removes, n_results);
    $display("full drops %0d, misses %0d, own-head results %0d, deepest queue %0d",
             n_full, n_miss, n_own_head, max_depth);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d errors, %0d results never arrived", n_errors,
               expected_results.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
